@@ design/tkf_pkg.sv @@
`default_nettype none
package tkf_pkg;

    localparam int unsigned STEP_W  = 25;
    localparam int unsigned VAR_W   = 32;
    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned MEAS_W  = 25;
    localparam int unsigned GAIN_W  = 25;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0] STEP_TIME_RST     = 25'd167772;
    localparam logic [VAR_W-1:0]  PROCESS_NOISE_RST = 32'd168;
    localparam logic [VAR_W-1:0]  MEASURE_NOISE_RST = 32'd1677722;
    localparam logic [VAR_W-1:0]  VARIANCE_RST      = 32'd8388608;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

    typedef struct packed {
        logic [STEP_W-1:0] step_time;
        logic [VAR_W-1:0]  process_noise;
        logic [VAR_W-1:0]  measure_noise;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic take;
    } lane_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_PRED,
        LANE_PRED2,
        LANE_DIV,
        LANE_CORR1,
        LANE_CORR2,
        LANE_DONE
    } lane_state_t;

    function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [36:0] v);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        hi = 37'sd2147483647;
        lo = -37'sd2147483648;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ design/tkf_in_if.sv @@
`default_nettype none
interface tkf_in_if;
    logic valid;
    logic ready;
    logic signed [tkf_pkg::ANGLE_W-1:0] roll_rate;
    logic signed [tkf_pkg::ANGLE_W-1:0] pitch_rate;
    logic signed [tkf_pkg::MEAS_W-1:0]  roll_measured;
    logic signed [tkf_pkg::MEAS_W-1:0]  pitch_measured;

    modport source (output valid, roll_rate, pitch_rate, roll_measured, pitch_measured,
                    input ready);
    modport sink (input valid, roll_rate, pitch_rate, roll_measured, pitch_measured,
                  output ready);
endinterface
`default_nettype wire

@@ design/tkf_out_if.sv @@
`default_nettype none
interface tkf_out_if;
    logic valid;
    logic ready;
    logic signed [tkf_pkg::ANGLE_W-1:0] roll_angle;
    logic signed [tkf_pkg::ANGLE_W-1:0] pitch_angle;

    modport source (output valid, roll_angle, pitch_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface
`default_nettype wire

@@ design/tkf_cfg_if.sv @@
`default_nettype none
interface tkf_cfg_if;
    logic valid;
    logic ready;
    logic [tkf_pkg::CFG_IDX_W-1:0] index;
    logic [tkf_pkg::VAR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/tkf_lane.sv @@
`default_nettype none
module tkf_lane (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tkf_pkg::cfg_t                       cfg,
    input  wire tkf_pkg::lane_ctl_t                  ctl,
    input  wire logic signed [tkf_pkg::ANGLE_W-1:0]  rate,
    input  wire logic signed [tkf_pkg::MEAS_W-1:0]   meas,
    output tkf_pkg::lane_stat_t                      stat,
    output logic signed [tkf_pkg::ANGLE_W-1:0]       angle
);
    import tkf_pkg::*;

    lane_state_t state_reg, state_next;

    logic signed [ANGLE_W-1:0] est_reg, est_next;
    logic [VAR_W-1:0]          var_reg, var_next;
    logic signed [ANGLE_W-1:0] rate_reg;
    logic signed [MEAS_W-1:0]  meas_reg;
    logic signed [57:0]        prod_reg;
    logic signed [ANGLE_W-1:0] x_reg;
    logic [VAR_W-1:0]          p_reg;
    logic [32:0]               den_reg;
    logic [33:0]               rem_reg;
    logic [GAIN_W-1:0]         k_reg;
    logic [4:0]                cnt_reg;
    logic signed [59:0]        kx_reg;
    logic [56:0]               pp_reg;

    logic [32:0]        p_sum;
    logic signed [57:0] prod_rnd;
    logic signed [36:0] x_pred;
    logic               ge;
    logic [33:0]        rem_diff;
    logic signed [33:0] innov;
    logic [GAIN_W-1:0]  one_minus_k;
    logic signed [59:0] kx_rnd;
    logic signed [36:0] x_corr;
    logic [56:0]        pp_rnd;

    always_comb
    begin
        p_sum       = {1'b0, var_reg} + {1'b0, cfg.process_noise};
        prod_rnd    = (prod_reg + 58'sd8388608) >>> 24;
        x_pred      = {{5{est_reg[31]}}, est_reg} + prod_rnd[36:0];
        ge          = rem_reg >= {1'b0, den_reg};
        rem_diff    = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        innov       = {{2{x_reg[31]}}, x_reg};
        innov       = {{9{meas_reg[24]}}, meas_reg} - innov;
        one_minus_k = 25'd16777216 - k_reg;
        kx_rnd      = (kx_reg + 60'sd8388608) >>> 24;
        x_corr      = {{5{x_reg[31]}}, x_reg} + kx_rnd[36:0];
        pp_rnd      = (pp_reg + 57'd8388608) >> 24;
    end

    always_comb
    begin
        state_next = state_reg;
        est_next   = est_reg;
        var_next   = var_reg;
        unique case (state_reg)
            LANE_IDLE:  if (ctl.start) state_next = LANE_PRED;
            LANE_PRED:  state_next = LANE_PRED2;
            LANE_PRED2: state_next = LANE_DIV;
            LANE_DIV:   if (cnt_reg == 5'd24) state_next = LANE_CORR1;
            LANE_CORR1: state_next = LANE_CORR2;
            LANE_CORR2:
            begin
                est_next   = sat_angle(x_corr);
                var_next   = (pp_rnd[56:32] != '0) ? 32'hFFFFFFFF : pp_rnd[31:0];
                state_next = LANE_DONE;
            end
            LANE_DONE:  if (ctl.take) state_next = LANE_IDLE;
            default:    state_next = LANE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LANE_IDLE;
            est_reg   <= '0;
            var_reg   <= VARIANCE_RST;
        end
        else
        begin
            state_reg <= state_next;
            est_reg   <= est_next;
            var_reg   <= var_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            LANE_IDLE:
            begin
                rate_reg <= rate;
                meas_reg <= meas;
            end
            LANE_PRED:
            begin
                prod_reg <= $signed({1'b0, cfg.step_time}) * rate_reg;
                p_reg    <= p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
            end
            LANE_PRED2:
            begin
                x_reg   <= sat_angle(x_pred);
                den_reg <= {1'b0, p_reg} + {1'b0, cfg.measure_noise};
                rem_reg <= {2'b0, p_reg};
                k_reg   <= '0;
                cnt_reg <= '0;
            end
            LANE_DIV:
            begin
                rem_reg <= {rem_diff[32:0], 1'b0};
                k_reg   <= {k_reg[GAIN_W-2:0], ge && (den_reg != '0)};
                cnt_reg <= cnt_reg + 5'd1;
            end
            LANE_CORR1:
            begin
                kx_reg <= $signed({1'b0, k_reg}) * innov;
                pp_reg <= one_minus_k * p_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.idle = (state_reg == LANE_IDLE);
    assign stat.done = (state_reg == LANE_DONE);
    assign angle     = est_reg;

endmodule
`default_nettype wire

@@ design/two_axis_tilt_kalman_filter_unit.sv @@
// Each lane steps an accepted item through PRED, PRED2, DIV, CORR1 and CORR2 into DONE;
// a new item is accepted only once both lanes are idle again. Each lane has a 25-step gain divider.
// A new item is taken while the previous result waits in the output register.
// Reset: asynchronous active low; estimates clear to 0, variances to 0.5,
// registers to their defaults.
`default_nettype none
module two_axis_tilt_kalman_filter_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    tkf_in_if.sink    in_ch,
    tkf_cfg_if.sink   cfg,
    tkf_out_if.source out_ch
);
    import tkf_pkg::*;

    cfg_t       cfg_reg;
    lane_ctl_t  ctl;
    lane_stat_t roll_stat, pitch_stat;
    logic signed [ANGLE_W-1:0] roll_lane_angle, pitch_lane_angle;
    logic out_valid_reg;
    logic signed [ANGLE_W-1:0] roll_out_reg, pitch_out_reg;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = roll_stat.idle && pitch_stat.idle;
    assign ctl.start   = in_ch.valid && in_ch.ready;
    assign ctl.take    = roll_stat.done && pitch_stat.done && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_time     <= STEP_TIME_RST;
            cfg_reg.process_noise <= PROCESS_NOISE_RST;
            cfg_reg.measure_noise <= MEASURE_NOISE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STEP_TIME:     cfg_reg.step_time     <= cfg.data[STEP_W-1:0];
                REG_PROCESS_NOISE: cfg_reg.process_noise <= cfg.data;
                REG_MEASURE_NOISE: cfg_reg.measure_noise <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    tkf_lane u_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (ctl),
        .rate  (in_ch.roll_rate),
        .meas  (in_ch.roll_measured),
        .stat  (roll_stat),
        .angle (roll_lane_angle)
    );

    tkf_lane u_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (ctl),
        .rate  (in_ch.pitch_rate),
        .meas  (in_ch.pitch_measured),
        .stat  (pitch_stat),
        .angle (pitch_lane_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.take)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            roll_out_reg  <= roll_lane_angle;
            pitch_out_reg <= pitch_lane_angle;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.roll_angle  = roll_out_reg;
    assign out_ch.pitch_angle = pitch_out_reg;

endmodule
`default_nettype wire

@@ tb/sv/tb_tkf_ifs.sv @@
`timescale 1ns / 100ps
// The channel interfaces come from the design files: tkf_in_if, tkf_out_if and tkf_cfg_if.
// This file holds the test-side helper types shared by the testbench top.
package tb_tkf_types;
    import tkf_pkg::*;

    typedef struct {
        logic signed [ANGLE_W-1:0] roll_rate;
        logic signed [ANGLE_W-1:0] pitch_rate;
        logic signed [MEAS_W-1:0]  roll_measured;
        logic signed [MEAS_W-1:0]  pitch_measured;
    } tilt_item_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
    } angle_pair_t;
endpackage

@@ tb/sv/tb_two_axis_tilt_kalman_filter_unit.sv @@
`timescale 1ns / 100ps
module tb_two_axis_tilt_kalman_filter_unit;
    import tkf_pkg::*;
    import tb_tkf_types::*;

    localparam int LATENCY = 31;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;

    tkf_in_if  in_ch();
    tkf_out_if out_ch();
    tkf_cfg_if cfg();

    two_axis_tilt_kalman_filter_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .cfg(cfg),
        .out_ch(out_ch)
    );

    // filter copy used for prediction
    logic [STEP_W-1:0] dt_q;
    logic [VAR_W-1:0]  q_var;
    logic [VAR_W-1:0]  r_var;
    logic signed [31:0] roll_x, pitch_x;
    logic [31:0] roll_p, pitch_p;

    tilt_item_t  pending_items[$];
    angle_pair_t expected_angles[$];

    int mismatches = 0;
    longint cycles = 0;
    int feed_gap = 0;
    int drain_gap = 0;
    int hold_off = 0;
    bit in_taken = 0;
    bit out_taken = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint round_q24(input longint v);
        return (v + 64'sd8388608) >>> 24;
    endfunction

    function automatic longint sat_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic void update_axis(inout logic signed [31:0] x_st,
                                        inout logic [31:0] p_st,
                                        input longint rate, input longint meas,
                                        output logic signed [31:0] angle);
        longint x;
        longint unsigned p, den, k, pn;
        x = sat_s32(longint'(x_st) + round_q24(longint'(dt_q) * rate));
        p = longint'(p_st) + longint'(q_var);
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        den = p + longint'(r_var);
        k = (den == 0) ? 0 : (p << 24) / den;
        x = sat_s32(x + round_q24(longint'(k) * (meas - x)));
        pn = round_q24(longint'((64'd16777216 - k) * p));
        if (pn > 64'hFFFF_FFFF)
            pn = 64'hFFFF_FFFF;
        x_st = x[31:0];
        p_st = pn[31:0];
        angle = x[31:0];
    endfunction

    function automatic void predict_angles(input tilt_item_t it);
        angle_pair_t e;
        update_axis(roll_x, roll_p, longint'(it.roll_rate), longint'(it.roll_measured),
                    e.roll_angle);
        update_axis(pitch_x, pitch_p, longint'(it.pitch_rate), longint'(it.pitch_measured),
                    e.pitch_angle);
        expected_angles.push_back(e);
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            feed_gap <= 0;
        end
        else if (in_ch.valid && !in_taken)
        begin
        end
        else if (feed_gap != 0)
        begin
            in_ch.valid <= 1'b0;
            feed_gap <= feed_gap - 1;
        end
        else if (pending_items.size() != 0)
        begin
            in_ch.valid <= 1'b1;
            in_ch.roll_rate <= pending_items[0].roll_rate;
            in_ch.pitch_rate <= pending_items[0].pitch_rate;
            in_ch.roll_measured <= pending_items[0].roll_measured;
            in_ch.pitch_measured <= pending_items[0].pitch_measured;
            void'(pending_items.pop_front());
            feed_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        end
        else
            in_ch.valid <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        out_taken <= rst_n && out_ch.valid && out_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            tilt_item_t it;
            it.roll_rate = in_ch.roll_rate;
            it.pitch_rate = in_ch.pitch_rate;
            it.roll_measured = in_ch.roll_measured;
            it.pitch_measured = in_ch.pitch_measured;
            predict_angles(it);
        end
        if (rst_n && cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_STEP_TIME:     dt_q = cfg.data[STEP_W-1:0];
                REG_PROCESS_NOISE: q_var = cfg.data;
                REG_MEASURE_NOISE: r_var = cfg.data;
                default: ;
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result roll=%h pitch=%h",
                             out_ch.roll_angle, out_ch.pitch_angle);
            end
            else
            begin
                angle_pair_t e;
                e = expected_angles.pop_front();
                if (e.roll_angle !== out_ch.roll_angle || e.pitch_angle !== out_ch.pitch_angle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch roll exp=%h got=%h pitch exp=%h got=%h",
                                 e.roll_angle, out_ch.roll_angle,
                                 e.pitch_angle, out_ch.pitch_angle);
                end
            end
        end
    end

    // long receiver stall
    always @(negedge clk)
    begin
        if (hold_off != 0)
            hold_off <= hold_off - 1;
    end

    always @(negedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            drain_gap <= 0;
        end
        else if (hold_off != 0)
            out_ch.ready <= 1'b0;
        else if (out_taken)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            drain_gap <= gap;
            out_ch.ready <= (gap == 0);
        end
        else if (!out_ch.ready)
        begin
            if (drain_gap != 0)
                drain_gap <= drain_gap - 1;
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[two_axis_tilt_kalman_filter_unit] ERROR");
            $finish;
        end
    end

    function automatic tilt_item_t rand_item(input int mode);
        tilt_item_t it;
        it.roll_rate = $urandom;
        it.pitch_rate = $urandom;
        if (mode != 0)
        begin
            it.roll_rate = $signed($urandom_range(0, 40000000)) - 20000000;
            it.pitch_rate = $signed($urandom_range(0, 40000000)) - 20000000;
        end
        it.roll_measured = $signed($urandom_range(0, 23592960)) - 11796480;
        it.pitch_measured = $signed($urandom_range(0, 23592960)) - 11796480;
        return it;
    endfunction

    function automatic tilt_item_t make_item(input logic signed [31:0] rr,
                                             input logic signed [31:0] pr,
                                             input logic signed [24:0] rm,
                                             input logic signed [24:0] pm);
        tilt_item_t it;
        it.roll_rate = rr;
        it.pitch_rate = pr;
        it.roll_measured = rm;
        it.pitch_measured = pm;
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending_items.size() != 0 || in_ch.valid || expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(rand_item($urandom_range(0, 4) != 0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.roll_rate = '0;
        in_ch.pitch_rate = '0;
        in_ch.roll_measured = '0;
        in_ch.pitch_measured = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_STEP_TIME;
        cfg.data = '0;
        dt_q = STEP_TIME_RST;
        q_var = PROCESS_NOISE_RST;
        r_var = MEASURE_NOISE_RST;
        roll_x = 0;
        pitch_x = 0;
        roll_p = VARIANCE_RST;
        pitch_p = VARIANCE_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes at default settings
        pending_items.push_back(make_item(32'sh7FFFFFFF, 32'sh80000000, 25'sd11796480,
                                          -25'sd11796480));
        pending_items.push_back(make_item(32'sh80000000, 32'sh7FFFFFFF, -25'sd11796480,
                                          25'sd11796480));
        pending_items.push_back(make_item(0, 0, 0, 0));
        pending_items.push_back(make_item(-1, 1, -1, 1));
        drain_all();

        // large dt drives angles into saturation
        write_reg(REG_STEP_TIME, 32'd16777216);
        write_reg(REG_PROCESS_NOISE, 32'hFFFFFFFF);
        write_reg(REG_MEASURE_NOISE, 32'hFFFFFFFF);
        write_reg(2'd3, 32'h12345678);
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(32'sh7FFFFFFF, 32'sh80000000, 0, 0));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(32'sh80000000, 32'sh7FFFFFFF, 0, 0));
        run_random(100);
        drain_all();

        // zero measurement noise and zero process noise
        write_reg(REG_STEP_TIME, 32'd1);
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASURE_NOISE, 32'd0);
        run_random(150);
        drain_all();

        write_reg(REG_STEP_TIME, 32'h1FFFFFF);
        write_reg(REG_PROCESS_NOISE, 32'd168);
        write_reg(REG_MEASURE_NOISE, 32'd1);
        run_random(150);
        drain_all();

        write_reg(REG_STEP_TIME, 32'd167772);
        write_reg(REG_PROCESS_NOISE, $urandom);
        write_reg(REG_MEASURE_NOISE, $urandom_range(1, 32'h00FFFFFF));
        @(negedge clk);
        hold_off = 600;
        run_random(250);
        drain_all();

        if (mismatches == 0)
            $display("[two_axis_tilt_kalman_filter_unit] OK");
        else
            $display("[two_axis_tilt_kalman_filter_unit] ERROR");
        $finish;
    end
endmodule

@@ two_axis_tilt_kalman_filter_unit.f @@
design/tkf_pkg.sv
design/tkf_in_if.sv
design/tkf_out_if.sv
design/tkf_cfg_if.sv
design/tkf_lane.sv
design/two_axis_tilt_kalman_filter_unit.sv
tb/sv/tb_tkf_ifs.sv
tb/sv/tb_two_axis_tilt_kalman_filter_unit.sv
